// ----- design/quaternion_to_euler_angles_macros.svh -----
// Assertion macros shared by the quaternion-to-Euler design files.
// Expects clk and rst_n in the including module's scope.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// Same-cycle implication, checked out of reset
`define QTE_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset
`define QTE_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- design/qte_pkg.sv -----
// Types, constants and step functions for the quaternion-to-Euler pipeline.
// No dependencies; used by the front, queue, back and top-level files.
package qte_pkg;

  localparam int SQ_STAGES = 31;
  localparam int TABLE_LEN = 24;

  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
  } out_t;

  // Queue entry: atan2 operands, pitch sine, and the radicand for its cosine
  typedef struct packed {
    logic signed [34:0] rx;
    logic signed [34:0] ry;
    logic signed [34:0] yx;
    logic signed [34:0] yy;
    logic signed [31:0] s;
    logic [61:0]        v;
    logic               clamped;
  } work_t;

  typedef struct packed {
    logic [61:0]        v;
    logic [61:0]        res;
    logic signed [34:0] rx;
    logic signed [34:0] ry;
    logic signed [34:0] yx;
    logic signed [34:0] yy;
    logic signed [31:0] s;
    logic               clamped;
  } sq_stage_t;

  typedef struct packed {
    logic signed [53:0] x;
    logic signed [53:0] y;
    logic [31:0]        acc;
    logic               zero;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
    logic  clamped;
  } cd_stage_t;

  // Arctangent table, 2^31 = pi
  function automatic logic [31:0] atan_entry(int unsigned i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;  1: r = 32'd316933406;
      2: r = 32'd167458907;  3: r = 32'd85004756;
      4: r = 32'd42667331;   5: r = 32'd21354465;
      6: r = 32'd10680350;   7: r = 32'd5340245;
      8: r = 32'd2670163;    9: r = 32'd1335087;
      10: r = 32'd667544;    11: r = 32'd333772;
      12: r = 32'd166886;    13: r = 32'd83443;
      14: r = 32'd41722;     15: r = 32'd20861;
      16: r = 32'd10430;     17: r = 32'd5215;
      18: r = 32'd2608;      19: r = 32'd1304;
      20: r = 32'd652;       21: r = 32'd326;
      22: r = 32'd163;       23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // One digit-pair of the restoring square root
  function automatic sq_stage_t sqrt_step(sq_stage_t a, int unsigned sh);
    sq_stage_t   r;
    logic [61:0] bitv;
    logic [61:0] trial;
    r     = a;
    bitv  = 62'(1) << sh;
    trial = a.res + bitv;
    if (a.v >= trial) begin
      r.v   = a.v - trial;
      r.res = (a.res >> 1) + bitv;
    end else begin
      r.res = a.res >> 1;
    end
    return r;
  endfunction

  // Scale by 2^16, fold the left half-plane onto the right
  function automatic lane_t cordic_init(logic signed [34:0] y, logic signed [34:0] x);
    lane_t              r;
    logic signed [53:0] xs;
    logic signed [53:0] ys;
    xs     = {{3{x[34]}}, x, 16'b0};
    ys     = {{3{y[34]}}, y, 16'b0};
    r.zero = (x == 35'sd0) && (y == 35'sd0);
    if (x[34]) begin
      r.x   = -xs;
      r.y   = -ys;
      r.acc = 32'h8000_0000;
    end else begin
      r.x   = xs;
      r.y   = ys;
      r.acc = 32'h0;
    end
    return r;
  endfunction

  // One vectoring iteration; shifts are floor shifts
  function automatic lane_t cordic_step(lane_t a, int unsigned i);
    lane_t              r;
    logic signed [53:0] xs;
    logic signed [53:0] ys;
    r  = a;
    xs = a.x >>> i;
    ys = a.y >>> i;
    if (!a.y[53]) begin
      r.x   = a.x + ys;
      r.y   = a.y - xs;
      r.acc = a.acc + atan_entry(i);
    end else begin
      r.x   = a.x - ys;
      r.y   = a.y + xs;
      r.acc = a.acc - atan_entry(i);
    end
    return r;
  endfunction

  // Round the accumulator to a 16-bit binary angle
  function automatic logic signed [15:0] lane_angle(lane_t a);
    logic [31:0] sum;
    sum = a.acc + 32'h0000_8000;
    return a.zero ? 16'sd0 : $signed(sum[31:16]);
  endfunction

endpackage

// ----- design/qte_front.sv -----
// Front end: component products, angle operands, pitch saturation and radicand.
// Depends on qte_pkg. Four register stages that advance together.
module qte_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qte_pkg::in_t  in_data,
  input  logic          q_full_i,
  output logic          q_push_o,
  output qte_pkg::work_t q_data_o
);

  logic [3:0] fv_r;
  logic       en;

  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, yz_r, wx_r, wy_r, xz_r, xy_r, wz_r;
  logic signed [34:0] rx2_r, ry2_r, yx2_r, yy2_r, rx3_r, ry3_r, yx3_r, yy3_r;
  logic signed [31:0] s2_r, s3_r;
  logic               c2_r, c3_r;
  logic [61:0]        sq3_r;
  qte_pkg::work_t     w4_r;

  logic signed [34:0] s_raw;
  logic signed [31:0] s_sat;
  logic               s_clamp;
  logic [30:0]        s_mag;

  // Advance unless the last stage holds a beat the queue cannot take
  assign en       = !fv_r[3] || !q_full_i;
  assign in_stall = !en;
  assign q_push_o = en && fv_r[3];
  assign q_data_o = w4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 4'b0;
    end else if (en) begin
      fv_r <= {fv_r[2:0], in_valid};
    end
  end

  // Stage 1: products, Q2.30
  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= in_data.q_w * in_data.q_w;
      xx_r <= in_data.q_x * in_data.q_x;
      yy_r <= in_data.q_y * in_data.q_y;
      zz_r <= in_data.q_z * in_data.q_z;
      yz_r <= in_data.q_y * in_data.q_z;
      wx_r <= in_data.q_w * in_data.q_x;
      wy_r <= in_data.q_w * in_data.q_y;
      xz_r <= in_data.q_x * in_data.q_z;
      xy_r <= in_data.q_x * in_data.q_y;
      wz_r <= in_data.q_w * in_data.q_z;
    end
  end

  // Saturate the pitch sine to plus or minus one
  always_comb begin
    s_raw = (35'(wy_r) - 35'(xz_r)) <<< 1;
    s_clamp = 1'b0;
    s_sat = 32'(s_raw);
    if (s_raw > 35'sd1073741824) begin
      s_sat   = 32'sd1073741824;
      s_clamp = 1'b1;
    end else if (s_raw < -35'sd1073741824) begin
      s_sat   = -32'sd1073741824;
      s_clamp = 1'b1;
    end
  end

  // Stage 2: sums of products
  always_ff @(posedge clk) begin
    if (en) begin
      ry2_r <= (35'(yz_r) + 35'(wx_r)) <<< 1;
      rx2_r <= 35'(ww_r) - 35'(xx_r) - 35'(yy_r) + 35'(zz_r);
      yy2_r <= (35'(xy_r) + 35'(wz_r)) <<< 1;
      yx2_r <= 35'(ww_r) + 35'(xx_r) - 35'(yy_r) - 35'(zz_r);
      s2_r  <= s_sat;
      c2_r  <= s_clamp;
    end
  end

  assign s_mag = s2_r[31] ? 31'(-s2_r) : s2_r[30:0];

  // Stage 3: square of the sine
  always_ff @(posedge clk) begin
    if (en) begin
      sq3_r <= s_mag * s_mag;
      rx3_r <= rx2_r;
      ry3_r <= ry2_r;
      yx3_r <= yx2_r;
      yy3_r <= yy2_r;
      s3_r  <= s2_r;
      c3_r  <= c2_r;
    end
  end

  // Stage 4: radicand 2^60 - s^2
  always_ff @(posedge clk) begin
    if (en) begin
      w4_r.v       <= (62'(1) << 60) - sq3_r;
      w4_r.rx      <= rx3_r;
      w4_r.ry      <= ry3_r;
      w4_r.yx      <= yx3_r;
      w4_r.yy      <= yy3_r;
      w4_r.s       <= s3_r;
      w4_r.clamped <= c3_r;
    end
  end

endmodule

// ----- design/qte_queue.sv -----
// Small register queue between the front and back ends.
// Depends on qte_pkg and the assertion macro header.
`include "quaternion_to_euler_angles_macros.svh"
module qte_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  qte_pkg::work_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output qte_pkg::work_t data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  qte_pkg::work_t    mem_r [DEPTH];
  logic [AW-1:0]     wr_r, rd_r;
  logic [AW:0]       cnt_r;

  assign full_o  = (cnt_r == (AW+1)'(DEPTH));
  assign valid_o = (cnt_r != '0);
  assign data_o  = mem_r[rd_r];

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_r] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) begin
        wr_r <= (wr_r == AW'(DEPTH-1)) ? '0 : wr_r + 1'b1;
      end
      if (pop_i) begin
        rd_r <= (rd_r == AW'(DEPTH-1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  `QTE_ASSERT_IMP(a_no_overflow, push_i, !full_o)
  `QTE_ASSERT_IMP(a_no_underflow, pop_i, valid_o)
  `QTE_ASSERT_IMP(a_count_bound, 1'b1, cnt_r <= (AW+1)'(DEPTH))

endmodule

// ----- design/qte_back.sv -----
// Back end: pipelined square root for the pitch cosine, then three CORDIC lanes.
// Depends on qte_pkg and the assertion macro header.
`include "quaternion_to_euler_angles_macros.svh"
module qte_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid_i,
  input  qte_pkg::work_t q_data_i,
  output logic           q_pop_o,
  output logic           out_valid,
  input  logic           out_stall,
  output qte_pkg::out_t  out_data
);

  localparam int NSQ = qte_pkg::SQ_STAGES;

  logic                  en;
  logic [NSQ-1:0]        sv_r;
  qte_pkg::sq_stage_t    sq_r [NSQ];
  logic [CORDIC_STEPS:0] cv_r;
  qte_pkg::cd_stage_t    cd_r [CORDIC_STEPS+1];
  logic                  ov_r;
  qte_pkg::out_t         od_r;
  qte_pkg::sq_stage_t    sq_head;
  qte_pkg::sq_stage_t    sq_last;

  // Advance everything unless the output beat is held
  assign en        = !ov_r || !out_stall;
  assign q_pop_o   = en && q_valid_i;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    sq_head.v       = q_data_i.v;
    sq_head.res     = '0;
    sq_head.rx      = q_data_i.rx;
    sq_head.ry      = q_data_i.ry;
    sq_head.yx      = q_data_i.yx;
    sq_head.yy      = q_data_i.yy;
    sq_head.s       = q_data_i.s;
    sq_head.clamped = q_data_i.clamped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      cv_r <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      sv_r <= {sv_r[NSQ-2:0], q_valid_i};
      cv_r <= {cv_r[CORDIC_STEPS-1:0], sv_r[NSQ-1]};
      ov_r <= cv_r[CORDIC_STEPS];
    end
  end

  // Square-root stages, one result bit each
  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k] <= qte_pkg::sqrt_step((k == 0) ? sq_head : sq_r[(k == 0) ? 0 : k-1],
                                      60 - 2*k);
      end
    end
  end

  assign sq_last = sq_r[NSQ-1];

  // Set up the three atan2 operands
  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0].roll    <= qte_pkg::cordic_init(sq_last.ry, sq_last.rx);
      cd_r[0].yaw     <= qte_pkg::cordic_init(sq_last.yy, sq_last.yx);
      cd_r[0].pitch   <= qte_pkg::cordic_init(35'(sq_last.s),
                                              35'(sq_last.res[30:0]));
      cd_r[0].clamped <= sq_last.clamped;
    end
  end

  // CORDIC iterations
  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cd
    always_ff @(posedge clk) begin
      if (en) begin
        cd_r[j+1].roll    <= qte_pkg::cordic_step(cd_r[j].roll, j);
        cd_r[j+1].pitch   <= qte_pkg::cordic_step(cd_r[j].pitch, j);
        cd_r[j+1].yaw     <= qte_pkg::cordic_step(cd_r[j].yaw, j);
        cd_r[j+1].clamped <= cd_r[j].clamped;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      od_r.roll_angle    <= qte_pkg::lane_angle(cd_r[CORDIC_STEPS].roll);
      od_r.pitch_angle   <= qte_pkg::lane_angle(cd_r[CORDIC_STEPS].pitch);
      od_r.yaw_angle     <= qte_pkg::lane_angle(cd_r[CORDIC_STEPS].yaw);
      od_r.pitch_clamped <= cd_r[CORDIC_STEPS].clamped;
    end
  end

  `QTE_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
  `QTE_ASSERT_IMP(a_pop_only_valid, q_pop_o, q_valid_i)
  `QTE_ASSERT_NEXT(a_clamp_flows, en && cv_r[CORDIC_STEPS] && cd_r[CORDIC_STEPS].clamped,
                   out_valid && out_data.pitch_clamped)

endmodule

// ----- design/quaternion_to_euler_angles.sv -----
// Quaternion to roll/pitch/yaw. Throughput one quaternion per cycle unless out_stall
// holds the pipeline; under stall, front-end beats wait in the queue.
// The 31-stage square root and CORDIC_STEPS CORDIC stages set the latency.
// Synchronous active-low reset clears all valid flags and queue pointers.
// Depends on qte_pkg, qte_front, qte_queue and qte_back.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qte_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output qte_pkg::out_t out_data
);

  logic           q_full, q_push, q_pop, q_valid;
  qte_pkg::work_t q_wdata, q_rdata;

  qte_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  qte_queue #(.DEPTH(4)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  qte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for quaternion_to_euler_angles: drives quaternion beats under varied
// idle/stall patterns and checks roll, pitch, yaw against a built-in predictor.
// Depends on qte_pkg and the quaternion_to_euler_angles RTL.
module testbench;

  localparam int STEPS       = 16;
  localparam int LATENCY     = 55;
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  qte_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  qte_pkg::out_t out_data;

  qte_pkg::out_t angles_q[$];
  int   mismatches = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;

  longint atan_tab[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10680350,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81};

  quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Vectoring CORDIC: atan2 as a 16-bit binary angle
  function automatic logic [15:0] atan2_angle(longint y, longint x);
    longint ax, ay, xs, ys, acc;
    logic [63:0] sum;
    if (x == 0 && y == 0) return 16'h0;
    ax  = x * 65536;
    ay  = y * 65536;
    acc = 0;
    if (ax < 0) begin
      ax  = -ax;
      ay  = -ay;
      acc = 64'sd2147483648;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = ax >>> i;
      ys = ay >>> i;
      if (ay >= 0) begin
        ax  = ax + ys;
        ay  = ay - xs;
        acc = acc + atan_tab[i];
      end else begin
        ax  = ax - ys;
        ay  = ay + xs;
        acc = acc - atan_tab[i];
      end
    end
    sum = acc + 64'd32768;
    return sum[31:16];
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic qte_pkg::out_t euler_of(qte_pkg::in_t q);
    qte_pkg::out_t r;
    longint w, x, y, z, s, c;
    w = longint'(q.q_w);
    x = longint'(q.q_x);
    y = longint'(q.q_y);
    z = longint'(q.q_z);
    r.roll_angle = atan2_angle(2 * (y * z + w * x), w * w - x * x - y * y + z * z);
    s = 2 * (w * y - x * z);
    r.pitch_clamped = 1'b0;
    if (s > 64'sd1073741824) begin
      s = 64'sd1073741824;
      r.pitch_clamped = 1'b1;
    end else if (s < -64'sd1073741824) begin
      s = -64'sd1073741824;
      r.pitch_clamped = 1'b1;
    end
    c = int_sqrt(longint'(64'd1 << 60) - s * s);
    r.pitch_angle = atan2_angle(s, c);
    r.yaw_angle = atan2_angle(2 * (x * y + w * z), w * w + x * x - y * y - z * z);
    return r;
  endfunction

  // Randomize receiver stall each cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check each result beat against the oldest prediction; watch for hangs
  always @(posedge clk) begin
    qte_pkg::out_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (angles_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          want = angles_q.pop_front();
          if (out_data.roll_angle !== want.roll_angle ||
              out_data.pitch_angle !== want.pitch_angle ||
              out_data.yaw_angle !== want.yaw_angle ||
              out_data.pitch_clamped !== want.pitch_clamped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
    end
  end

  // Present one quaternion beat; valid stays high after acceptance
  task automatic send_quat(qte_pkg::in_t q);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (in_stall);
    angles_q.push_back(euler_of(q));
  endtask

  task automatic send_comps(int w, int x, int y, int z);
    qte_pkg::in_t q;
    q.q_w = 16'(w);
    q.q_x = 16'(x);
    q.q_y = 16'(y);
    q.q_z = 16'(z);
    send_quat(q);
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_comps(0, 0, 0, 0);                       // zero vector in the roll and yaw atan2
    send_comps(32767, 0, 0, 0);                   // identity
    send_comps(-32768, 0, 0, 0);
    send_comps(0, 32767, 0, 0);                   // negative x operand for roll
    send_comps(0, 0, 32767, 0);
    send_comps(0, 0, 0, 32767);
    send_comps(-32768, -32768, -32768, -32768);
    send_comps(32767, 32767, 32767, 32767);
    send_comps(32767, 0, 32767, 0);               // pitch saturated high
    send_comps(32767, 0, -32768, 0);              // pitch saturated low
    send_comps(-16384, 0, -32768, 0);             // argument exactly one, no flag
    send_comps(16384, 0, -32768, 0);              // argument exactly minus one
    send_comps(23170, 0, 23170, 0);               // pitch near pi/2
    send_comps(0, 32767, 0, 32767);
    send_comps(0, -32768, 0, 1);                  // angle near plus pi wraps
    send_comps(1, -1, 1, -1);
    send_comps(-1, 0, 0, 0);
    send_comps(23170, 23170, 0, 0);
    send_comps(23170, 0, 0, 23170);
    send_comps(-32768, 32767, -32768, 32767);
  endtask

  task automatic test_random(int n, int idle, int stall);
    qte_pkg::in_t q;
    idle_pct  = idle;
    stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      q = qte_pkg::in_t'({$urandom, $urandom});
      case ($urandom_range(3))
        0: ;                                      // full range
        1: begin                                  // small magnitudes
          q.q_w = $signed(16'($urandom_range(0, 255))) - 16'sd128;
          q.q_x = $signed(16'($urandom_range(0, 255))) - 16'sd128;
        end
        2: begin                                  // near the pitch limit
          q.q_x = 16'($urandom_range(0, 64)) - 16'sd32;
          q.q_y = q.q_w;
        end
        default: begin                            // one dominant component
          q.q_x = q.q_x >>> 4;
          q.q_y = q.q_y >>> 4;
          q.q_z = q.q_z >>> 4;
        end
      endcase
      send_quat(q);
    end
  endtask

  // Hold the sender until everything in flight has come back
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    while (angles_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(325, 0, 0);
    test_drain_pause();
    test_random(325, 84, 0);
    test_random(325, 0, 84);
    test_random(325, 24, 24);
    in_valid <= 1'b0;
    while (angles_q.size() != 0) @(posedge clk);
    repeat (LATENCY * 2) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/qte_pkg.sv
design/qte_front.sv
design/qte_queue.sv
design/qte_back.sv
design/quaternion_to_euler_angles.sv
tb/sv/testbench.sv
